[hw/rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// shared widths, register map, reset values and lane control types for the
// touch coordinate conditioner
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int COORD_W = 12;
   localparam int OPT_W   = 4;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 3;

   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

   // register indexes
   localparam logic [IDX_W-1:0] REG_X_OFFSET      = 3'd0;
   localparam logic [IDX_W-1:0] REG_Y_OFFSET      = 3'd1;
   localparam logic [IDX_W-1:0] REG_X_TOP         = 3'd2;
   localparam logic [IDX_W-1:0] REG_Y_TOP         = 3'd3;
   localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
   localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
   localparam logic [IDX_W-1:0] REG_OPTIONS       = 3'd6;

   // register reset values
   localparam logic [COORD_W-1:0] RST_X_OFFSET      = 12'd300;
   localparam logic [COORD_W-1:0] RST_Y_OFFSET      = 12'd200;
   localparam logic [COORD_W-1:0] RST_X_TOP         = 12'd3800;
   localparam logic [COORD_W-1:0] RST_Y_TOP         = 12'd3800;
   localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
   localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd240;
   localparam logic [OPT_W-1:0]   RST_OPTIONS       = 4'd0;

   // option bits
   localparam int OPT_SWAP     = 0;
   localparam int OPT_INVERT_X = 1;
   localparam int OPT_INVERT_Y = 2;
   localparam int OPT_AVERAGE  = 3;

   typedef struct packed {
      logic start;
      logic invert;
      logic avg_en;
      logic full;
   } lane_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic [COORD_W-1:0] pos;
   } lane_stat_type;

endpackage

[hw/rtl/tcc_serial_mul.sv]
// ----------------------------------------------------------------------------
// tcc_serial_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module tcc_serial_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tcc_pkg::COORD_W-1:0]   mcand,
   input  logic [tcc_pkg::COORD_W-1:0]   mplier,
   output logic                          busy,
   output logic [tcc_pkg::PROD_W-1:0]    product
);
   import tcc_pkg::*;

   localparam int CNT_W = $clog2(COORD_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COORD_W-1:0] hi_ff, hi_in;
   logic [COORD_W-1:0] lo_ff, lo_in;
   logic [COORD_W-1:0] mcand_ff, mcand_in;
   logic [COORD_W:0]   partial;

   assign partial = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         hi_in    = '0;
         lo_in    = mplier;
         mcand_in = mcand;
      end else if (busy_ff) begin
         hi_in  = partial[COORD_W:1];
         lo_in  = {partial[0], lo_ff[COORD_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(COORD_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign busy    = busy_ff;
   assign product = {hi_ff, lo_ff};

endmodule

[hw/rtl/tcc_serial_div.sv]
// ----------------------------------------------------------------------------
// tcc_serial_div
// restoring divider, one quotient bit per cycle; the upper dividend half
// must already be below the divisor so the quotient fits in twelve bits
// ----------------------------------------------------------------------------
module tcc_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tcc_pkg::COORD_W-1:0]   dividend_hi,
   input  logic [tcc_pkg::COORD_W-1:0]   dividend_lo,
   input  logic [tcc_pkg::COORD_W-1:0]   divisor,
   output logic                          busy,
   output logic [tcc_pkg::COORD_W-1:0]   quotient
);
   import tcc_pkg::*;

   localparam int CNT_W = $clog2(COORD_W);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] shf_ff, shf_in;
   logic [COORD_W-1:0] dvs_ff, dvs_in;
   logic [COORD_W:0]   shifted;
   logic [COORD_W:0]   trial;
   logic               fits;

   assign shifted = {rem_ff, shf_ff[COORD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend_hi;
         shf_in  = dividend_lo;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[COORD_W-1:0] : shifted[COORD_W-1:0];
         shf_in = {shf_ff[COORD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(COORD_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = shf_ff;

endmodule

[hw/rtl/tcc_axis_lane.sv]
// ----------------------------------------------------------------------------
// tcc_axis_lane
// one axis: offset, serial scale by resolution over span, inversion and the
// moving-average window with its running sum
// ----------------------------------------------------------------------------
module tcc_axis_lane #(
   parameter int WINDOW_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcc_pkg::lane_ctrl_type                 ctrl,
   input  logic [tcc_pkg::COORD_W-1:0]            raw,
   input  logic [tcc_pkg::COORD_W-1:0]            offset,
   input  logic [tcc_pkg::COORD_W-1:0]            far_val,
   input  logic [tcc_pkg::COORD_W-1:0]            res,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]      fill,
   output tcc_pkg::lane_stat_type                 stat
);
   import tcc_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = COORD_W + FILL_W;

   localparam logic [2:0] LS_IDLE   = 3'd0;
   localparam logic [2:0] LS_MUL    = 3'd1;
   localparam logic [2:0] LS_DIV    = 3'd2;
   localparam logic [2:0] LS_POST   = 3'd3;
   localparam logic [2:0] LS_AVG_GO = 3'd4;
   localparam logic [2:0] LS_AVG    = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic               inv_ff, inv_in;
   logic               avg_ff, avg_in;
   logic               full_ff, full_in;
   logic [COORD_W-1:0] span_ff, span_in;
   logic [COORD_W-1:0] res_ff, res_in;
   logic [COORD_W-1:0] scaled_ff, scaled_in;
   logic [COORD_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COORD_W-1:0] win_ff [WINDOW_DEPTH];
   logic               win_shift;

   logic [COORD_W-1:0] delta;
   logic [COORD_W-1:0] span_now;
   logic [COORD_W-1:0] flipped;
   logic [COORD_W-1:0] oldest;
   logic               saturate;

   logic               mul_start, mul_busy;
   logic [PROD_W-1:0]  product;
   logic               div_start, div_busy;
   logic [COORD_W-1:0] div_hi, div_lo, div_dvs, quotient;

   // clamped offset subtraction and span
   assign delta    = (raw > offset) ? (raw - offset) : '0;
   assign span_now = (far_val > offset) ? (far_val - offset) : '0;

   // quotient would reach 4096 when the upper product half is not below span
   assign saturate = (span_ff == '0) || (product[PROD_W-1:COORD_W] >= span_ff);
   assign flipped  = inv_ff ? ((res_ff > scaled_ff) ? (res_ff - scaled_ff) : '0)
                            : scaled_ff;
   assign oldest   = full_ff ? win_ff[WINDOW_DEPTH-1] : '0;

   assign mul_start = (state_ff == LS_IDLE) && ctrl.start;
   assign div_start = ((state_ff == LS_MUL) && !mul_busy && !saturate) ||
                      (state_ff == LS_AVG_GO);

   always_comb begin
      if (state_ff == LS_MUL) begin
         div_hi  = product[PROD_W-1:COORD_W];
         div_lo  = product[COORD_W-1:0];
         div_dvs = span_ff;
      end else begin
         div_hi  = COORD_W'(sum_ff >> COORD_W);
         div_lo  = sum_ff[COORD_W-1:0];
         div_dvs = COORD_W'(fill);
      end
   end

   always_comb begin
      state_in  = state_ff;
      inv_in    = inv_ff;
      avg_in    = avg_ff;
      full_in   = full_ff;
      span_in   = span_ff;
      res_in    = res_ff;
      scaled_in = scaled_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      win_shift = 1'b0;
      unique case (state_ff)
         LS_IDLE: begin
            if (ctrl.start) begin
               inv_in   = ctrl.invert;
               avg_in   = ctrl.avg_en;
               full_in  = ctrl.full;
               span_in  = span_now;
               res_in   = res;
               state_in = LS_MUL;
            end
         end
         LS_MUL: begin
            if (!mul_busy) begin
               if (saturate) begin
                  scaled_in = COORD_MAX;
                  state_in  = LS_POST;
               end else begin
                  state_in = LS_DIV;
               end
            end
         end
         LS_DIV: begin
            if (!div_busy) begin
               scaled_in = quotient;
               state_in  = LS_POST;
            end
         end
         LS_POST: begin
            if (avg_ff) begin
               sum_in    = SUM_W'(sum_ff + SUM_W'(flipped) - SUM_W'(oldest));
               win_shift = 1'b1;
               state_in  = LS_AVG_GO;
            end else begin
               pos_in   = flipped;
               state_in = LS_IDLE;
            end
         end
         LS_AVG_GO: begin
            state_in = LS_AVG;
         end
         LS_AVG: begin
            if (!div_busy) begin
               pos_in   = quotient;
               state_in = LS_IDLE;
            end
         end
         default: begin
            state_in = LS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
      end
      inv_ff    <= inv_in;
      avg_ff    <= avg_in;
      full_ff   <= full_in;
      span_ff   <= span_in;
      res_ff    <= res_in;
      scaled_ff <= scaled_in;
      pos_ff    <= pos_in;
   end

   // window shift line, newest at the head
   always_ff @(posedge clock) begin
      if (win_shift) begin
         win_ff[0] <= flipped;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   tcc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (delta),
      .mplier  (res),
      .busy    (mul_busy),
      .product (product)
   );

   tcc_serial_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi (div_hi),
      .dividend_lo (div_lo),
      .divisor     (div_dvs),
      .busy        (div_busy),
      .quotient    (quotient)
   );

   assign stat.busy = (state_ff != LS_IDLE);
   assign stat.pos  = pos_ff;

endmodule

[hw/rtl/touch_coordinate_conditioner_core.sv]
// ----------------------------------------------------------------------------
// touch_coordinate_conditioner_core
// turns raw resistive touch sample pairs into calibrated, optionally
// averaged screen coordinates
// ----------------------------------------------------------------------------
// A released request (pen_down low) answers with pressed low and the last
// pressed point through the pending and output registers. Pressed requests
// are folded into a running accumulator register; the one flagged last_pair
// then runs through two identical axis lanes in parallel, each a twelve-step
// bit-serial multiply by the resolution followed by a twelve-step
// bit-serial divide by the span. When the moving average is on, a point
// also runs a third twelve-step divide by the window fill count. A
// saturated axis skips its span divide. The block takes one request at a
// time; a finished result sits in the output register, so the next request
// can be taken while it waits. The averaging window is a shift line of
// WINDOW_DEPTH entries per axis with a running sum; no clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module touch_coordinate_conditioner_core #(
   parameter int WINDOW_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_pen_down,
   input  logic [tcc_pkg::COORD_W-1:0]    req_raw_x,
   input  logic [tcc_pkg::COORD_W-1:0]    req_raw_y,
   input  logic                           req_first_pair,
   input  logic                           req_last_pair,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pressed,
   output logic [tcc_pkg::COORD_W-1:0]    rsp_pos_x,
   output logic [tcc_pkg::COORD_W-1:0]    rsp_pos_y,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tcc_pkg::ADDR_W-1:0]     paddr,
   input  logic [tcc_pkg::DATA_W-1:0]     pwdata,
   output logic [tcc_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import tcc_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // configuration registers
   logic [COORD_W-1:0] x_offset_ff, y_offset_ff, x_top_ff, y_top_ff;
   logic [COORD_W-1:0] width_ff, height_ff;
   logic [OPT_W-1:0]   options_ff;
   logic               csr_write;
   logic [IDX_W-1:0]   csr_index;

   // request-side state
   logic [1:0]         state_ff, state_in;
   logic [COORD_W-1:0] accum_x_ff, accum_x_in;
   logic [COORD_W-1:0] accum_y_ff, accum_y_in;
   logic [COORD_W-1:0] held_x_ff, held_x_in;
   logic [COORD_W-1:0] held_y_ff, held_y_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               pend_pressed_ff, pend_pressed_in;
   logic [COORD_W-1:0] pend_x_ff, pend_x_in;
   logic [COORD_W-1:0] pend_y_ff, pend_y_in;
   logic [COORD_W:0]   mix_x, mix_y;
   logic               req_take;
   logic               window_full;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pressed_ff, rsp_pressed_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic               out_free;

   // lanes
   lane_ctrl_type      ctrl_x, ctrl_y;
   lane_stat_type      stat_x, stat_y;
   logic [COORD_W-1:0] lane_raw_x, lane_raw_y;

   // ---------------------------------------------------------------------
   // register port: writes on the access phase, reads decoded directly
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= RST_X_OFFSET;
         y_offset_ff <= RST_Y_OFFSET;
         x_top_ff    <= RST_X_TOP;
         y_top_ff    <= RST_Y_TOP;
         width_ff    <= RST_SCREEN_WIDTH;
         height_ff   <= RST_SCREEN_HEIGHT;
         options_ff  <= RST_OPTIONS;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_X_OFFSET:      x_offset_ff <= pwdata[COORD_W-1:0];
            REG_Y_OFFSET:      y_offset_ff <= pwdata[COORD_W-1:0];
            REG_X_TOP:         x_top_ff    <= pwdata[COORD_W-1:0];
            REG_Y_TOP:         y_top_ff    <= pwdata[COORD_W-1:0];
            REG_SCREEN_WIDTH:  width_ff    <= pwdata[COORD_W-1:0];
            REG_SCREEN_HEIGHT: height_ff   <= pwdata[COORD_W-1:0];
            REG_OPTIONS:       options_ff  <= pwdata[OPT_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_X_OFFSET:      prdata = DATA_W'(x_offset_ff);
         REG_Y_OFFSET:      prdata = DATA_W'(y_offset_ff);
         REG_X_TOP:         prdata = DATA_W'(x_top_ff);
         REG_Y_TOP:         prdata = DATA_W'(y_top_ff);
         REG_SCREEN_WIDTH:  prdata = DATA_W'(width_ff);
         REG_SCREEN_HEIGHT: prdata = DATA_W'(height_ff);
         REG_OPTIONS:       prdata = DATA_W'(options_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // request side: accumulate pairs, launch the lanes on the last pair
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // truncating average of accumulator and new sample
   assign mix_x = {1'b0, accum_x_ff} + {1'b0, req_raw_x};
   assign mix_y = {1'b0, accum_y_ff} + {1'b0, req_raw_y};

   assign window_full = (fill_ff == FILL_W'(WINDOW_DEPTH));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // optional axis swap ahead of calibration
   assign lane_raw_x = options_ff[OPT_SWAP] ? accum_y_ff : accum_x_ff;
   assign lane_raw_y = options_ff[OPT_SWAP] ? accum_x_ff : accum_y_ff;

   always_comb begin
      ctrl_x.start  = (state_ff == ST_START);
      ctrl_x.invert = options_ff[OPT_INVERT_X];
      ctrl_x.avg_en = options_ff[OPT_AVERAGE];
      ctrl_x.full   = window_full;
      ctrl_y.start  = (state_ff == ST_START);
      ctrl_y.invert = options_ff[OPT_INVERT_Y];
      ctrl_y.avg_en = options_ff[OPT_AVERAGE];
      ctrl_y.full   = window_full;
   end

   always_comb begin
      state_in        = state_ff;
      accum_x_in      = accum_x_ff;
      accum_y_in      = accum_y_ff;
      held_x_in       = held_x_ff;
      held_y_in       = held_y_ff;
      fill_in         = fill_ff;
      pend_pressed_in = pend_pressed_ff;
      pend_x_in       = pend_x_ff;
      pend_y_in       = pend_y_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_pressed_in  = rsp_pressed_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (!req_pen_down) begin
                  // released: repeat the last pressed point
                  pend_pressed_in = 1'b0;
                  pend_x_in       = held_x_ff;
                  pend_y_in       = held_y_ff;
                  state_in        = ST_EMIT;
               end else begin
                  if (req_first_pair) begin
                     accum_x_in = req_raw_x;
                     accum_y_in = req_raw_y;
                  end else if (req_raw_x != '0 && req_raw_y != '0) begin
                     accum_x_in = mix_x[COORD_W:1];
                     accum_y_in = mix_y[COORD_W:1];
                  end
                  if (req_last_pair) begin
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_START: begin
            // lanes latch their inputs here; the fill count moves with them
            if (options_ff[OPT_AVERAGE] && !window_full) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!stat_x.busy && !stat_y.busy) begin
               pend_pressed_in = 1'b1;
               pend_x_in       = stat_x.pos;
               pend_y_in       = stat_y.pos;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pressed_in = pend_pressed_ff;
               rsp_x_in       = pend_x_ff;
               rsp_y_in       = pend_y_ff;
               if (pend_pressed_ff) begin
                  held_x_in = pend_x_ff;
                  held_y_in = pend_y_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accum_x_ff   <= '0;
         accum_y_ff   <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_x_ff   <= accum_x_in;
         accum_y_ff   <= accum_y_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_pressed_ff <= pend_pressed_in;
      pend_x_ff       <= pend_x_in;
      pend_y_ff       <= pend_y_in;
      rsp_pressed_ff  <= rsp_pressed_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
   end

   // ---------------------------------------------------------------------
   // axis lanes, x settings follow the swapped x value
   // ---------------------------------------------------------------------
   tcc_axis_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl_x),
      .raw     (lane_raw_x),
      .offset  (x_offset_ff),
      .far_val (x_top_ff),
      .res     (width_ff),
      .fill    (fill_ff),
      .stat    (stat_x)
   );

   tcc_axis_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl_y),
      .raw     (lane_raw_y),
      .offset  (y_offset_ff),
      .far_val (y_top_ff),
      .res     (height_ff),
      .fill    (fill_ff),
      .stat    (stat_y)
   );

   // result outputs
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pressed = rsp_pressed_ff;
   assign rsp_pos_x   = rsp_x_ff;
   assign rsp_pos_y   = rsp_y_ff;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch coordinate conditioner testbench
// drives sample-pair requests and register writes into the conditioner core,
// predicts every point with a behavioral model kept alongside, and compares
// each point leaving the block field by field with the oldest expected point
// ----------------------------------------------------------------------------
module tb;

   import tcc_pkg::*;

   // block geometry and run pacing
   localparam int      WIN_DEPTH    = 4;
   localparam int      DRAIN_CYCLES = 80;
   localparam int      HOLD_CYCLES  = 400;     // long receiver hold-off
   localparam int      PHASE_ITEMS  = 100;
   localparam int      NUM_PHASES   = 8;
   localparam int      MAX_REPORTS  = 10;
   localparam realtime RUN_LIMIT    = 10ms;

   // address beyond the register map, writes there must be dropped
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   // one request as it goes onto the request channel
   typedef struct packed {
      logic               pen_down;
      logic [COORD_W-1:0] raw_x;
      logic [COORD_W-1:0] raw_y;
      logic               first_pair;
      logic               last_pair;
   } touch_req_type;

   // one point as it leaves on the result channel
   typedef struct packed {
      logic               pressed;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
   } touch_pt_type;

   // directed row: request plus an optional hand-written point
   typedef struct packed {
      touch_req_type req;
      logic          typed;
      touch_pt_type  want;
   } touch_row_type;

   // clock, reset and all block inputs start at known values
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_pen_down   = 1'b0;
   logic [COORD_W-1:0] req_raw_x      = '0;
   logic [COORD_W-1:0] req_raw_y      = '0;
   logic               req_first_pair = 1'b0;
   logic               req_last_pair  = 1'b0;
   logic               rsp_stall      = 1'b0;
   logic               psel           = 1'b0;
   logic               penable        = 1'b0;
   logic               pwrite         = 1'b0;
   logic [ADDR_W-1:0]  paddr          = '0;
   logic [DATA_W-1:0]  pwdata         = '0;

   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_pressed;
   logic [COORD_W-1:0] rsp_pos_x;
   logic [COORD_W-1:0] rsp_pos_y;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   // shadow of the block: calibration registers and point history
   logic [COORD_W-1:0] cal_reg [0:6];
   logic [COORD_W-1:0] accum_x, accum_y;
   logic [COORD_W-1:0] held_x, held_y;
   logic [COORD_W-1:0] win_x [0:WIN_DEPTH-1];
   logic [COORD_W-1:0] win_y [0:WIN_DEPTH-1];
   int unsigned        win_fill;

   // points still owed by the block, oldest first
   touch_pt_type       pending_pts[$];
   touch_row_type      plan[$];
   touch_pt_type       seen_pt, due_pt;
   int                 mismatch_count = 0;

   // pacing controls shared between the stimulus and the receiver
   bit                 quiet          = 1'b0;
   bit                 long_hold_req  = 1'b0;

   touch_coordinate_conditioner_core #(
      .WINDOW_DEPTH (WIN_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pen_down   (req_pen_down),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_first_pair (req_first_pair),
      .req_last_pair  (req_last_pair),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pressed    (rsp_pressed),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // every failure goes through here, only the first few are printed
   task automatic flag_error(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int rand_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // raw coordinate biased toward zero and the top of the range
   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return COORD_MAX;
         2: return COORD_W'($urandom_range(0, 15));
         3: return COORD_W'($urandom_range(4080, 4095));
         default: return COORD_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // one axis: clamp at the offset, scale by resolution over span,
   // saturate, then the optional inversion floored at zero
   function automatic logic [COORD_W-1:0] scale_axis(
      input logic [COORD_W-1:0] v,
      input logic [COORD_W-1:0] off,
      input logic [COORD_W-1:0] top,
      input logic [COORD_W-1:0] res,
      input logic               inv
   );
      int unsigned span, delta, s;
      span  = (top > off) ? top - off : 0;
      delta = (v > off) ? v - off : 0;
      if (span == 0) begin
         s = COORD_MAX;
      end else begin
         s = (delta * res) / span;
         if (s > COORD_MAX) s = COORD_MAX;
      end
      if (inv) s = (res > s) ? res - s : 0;
      return s[COORD_W-1:0];
   endfunction

   // advance the shadow by one accepted request and work out its point
   task automatic predict_touch(input touch_req_type r, output bit emits,
                                output touch_pt_type pt);
      logic [COORD_W:0]   sum_x, sum_y;
      logic [COORD_W-1:0] cx, cy, tmp;
      logic [OPT_W-1:0]   opt;
      int unsigned        acc_x, acc_y;
      emits = 1'b0;
      pt    = '0;
      opt   = cal_reg[REG_OPTIONS][OPT_W-1:0];
      if (!r.pen_down) begin
         // released: report the last pressed point, history untouched
         emits = 1'b1;
         pt    = {1'b0, held_x, held_y};
      end else begin
         if (r.first_pair) begin
            accum_x = r.raw_x;
            accum_y = r.raw_y;
         end else if (r.raw_x != 0 && r.raw_y != 0) begin
            sum_x   = {1'b0, accum_x} + {1'b0, r.raw_x};
            sum_y   = {1'b0, accum_y} + {1'b0, r.raw_y};
            accum_x = sum_x[COORD_W:1];
            accum_y = sum_y[COORD_W:1];
         end
         if (r.last_pair) begin
            cx = accum_x;
            cy = accum_y;
            if (opt[OPT_SWAP]) begin
               tmp = cx;
               cx  = cy;
               cy  = tmp;
            end
            cx = scale_axis(cx, cal_reg[REG_X_OFFSET], cal_reg[REG_X_TOP],
                            cal_reg[REG_SCREEN_WIDTH], opt[OPT_INVERT_X]);
            cy = scale_axis(cy, cal_reg[REG_Y_OFFSET], cal_reg[REG_Y_TOP],
                            cal_reg[REG_SCREEN_HEIGHT], opt[OPT_INVERT_Y]);
            if (opt[OPT_AVERAGE]) begin
               for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                  win_x[i] = win_x[i-1];
                  win_y[i] = win_y[i-1];
               end
               win_x[0] = cx;
               win_y[0] = cy;
               if (win_fill < WIN_DEPTH) win_fill++;
               acc_x = 0;
               acc_y = 0;
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  if (i < win_fill) begin
                     acc_x += win_x[i];
                     acc_y += win_y[i];
                  end
               end
               cx = COORD_W'(acc_x / win_fill);
               cy = COORD_W'(acc_y / win_fill);
            end
            held_x = cx;
            held_y = cy;
            emits  = 1'b1;
            pt     = {1'b1, cx, cy};
         end
      end
   endtask

   // offer one request and hold it until the block takes it
   task automatic send_touch(input touch_req_type r, input logic typed,
                             input touch_pt_type want);
      bit           emits;
      touch_pt_type pred;
      req_valid      <= 1'b1;
      req_pen_down   <= r.pen_down;
      req_raw_x      <= r.raw_x;
      req_raw_y      <= r.raw_y;
      req_first_pair <= r.first_pair;
      req_last_pair  <= r.last_pair;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_touch(r, emits, pred);
      if (emits) pending_pts.push_back(typed ? want : pred);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (rand_gap()) @(posedge clock);
      end
   endtask

   // stop offering, let every owed point arrive, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write: setup cycle, then access until pready, then back to idle
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_OPTIONS) cal_reg[idx] = {{(COORD_W-OPT_W){1'b0}}, val[OPT_W-1:0]};
      else if (idx != REG_UNUSED) cal_reg[idx] = val[COORD_W-1:0];
      @(posedge clock);
   endtask

   // write a register and read it straight back
   task automatic csr_write_check(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      logic [DATA_W-1:0] got;
      csr_write(idx, val);
      psel    <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got      = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== DATA_W'(cal_reg[idx]))
         flag_error($sformatf("register %0d read back %0h, expected %0h",
                              idx, got, cal_reg[idx]));
      @(posedge clock);
   endtask

   // calibration settings for each phase: fixed extremes first, then random
   task automatic program_phase(input int phase);
      logic [COORD_W-1:0] xo, yo, xt, yt, sw, sh;
      logic [OPT_W-1:0]   opt;
      case (phase)
         1: begin
            // reset geometry with every option on
            {xo, yo, xt, yt, sw, sh} = {RST_X_OFFSET, RST_Y_OFFSET, RST_X_TOP,
                                        RST_Y_TOP, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT};
            opt = '0;
            opt[OPT_SWAP]     = 1'b1;
            opt[OPT_INVERT_X] = 1'b1;
            opt[OPT_INVERT_Y] = 1'b1;
            opt[OPT_AVERAGE]  = 1'b1;
         end
         2: begin
            // full-range x, y with top below offset, both axes inverted
            {xo, xt, yo, yt, sw, sh} = {12'd0, COORD_MAX, COORD_MAX, 12'd0,
                                        COORD_MAX, 12'd1};
            opt = '0;
            opt[OPT_INVERT_X] = 1'b1;
            opt[OPT_INVERT_Y] = 1'b1;
         end
         3: begin
            // zero span on x, one-count span on y so scaling saturates
            {xo, xt, yo, yt, sw, sh} = {COORD_MAX, COORD_MAX, 12'd0, 12'd1,
                                        12'd1, COORD_MAX};
            opt = '0;
            opt[OPT_SWAP]    = 1'b1;
            opt[OPT_AVERAGE] = 1'b1;
         end
         4: begin
            // identity-like mapping with averaging
            {xo, xt, yo, yt, sw, sh} = {12'd0, COORD_MAX, 12'd0, COORD_MAX,
                                        COORD_MAX, COORD_MAX};
            opt = '0;
            opt[OPT_AVERAGE] = 1'b1;
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               // panel-like calibration
               xo = COORD_W'($urandom_range(0, 600));
               yo = COORD_W'($urandom_range(0, 600));
               xt = COORD_W'($urandom_range(3000, 4095));
               yt = COORD_W'($urandom_range(3000, 4095));
               sw = COORD_W'($urandom_range(1, 1024));
               sh = COORD_W'($urandom_range(1, 1024));
            end else begin
               xo = rand_coord();
               yo = rand_coord();
               xt = rand_coord();
               yt = rand_coord();
               sw = COORD_W'($urandom_range(1, 4095));
               sh = COORD_W'($urandom_range(1, 4095));
            end
            opt = OPT_W'($urandom_range(0, 15));
         end
      endcase
      csr_write_check(REG_X_OFFSET, DATA_W'(xo));
      csr_write_check(REG_Y_OFFSET, DATA_W'(yo));
      csr_write_check(REG_X_TOP, DATA_W'(xt));
      csr_write_check(REG_Y_TOP, DATA_W'(yt));
      csr_write_check(REG_SCREEN_WIDTH, DATA_W'(sw));
      csr_write_check(REG_SCREEN_HEIGHT, DATA_W'(sh));
      csr_write_check(REG_OPTIONS, DATA_W'(opt));
      // a write past the register map must change nothing
      if (phase == 2) csr_write(REG_UNUSED, $urandom);
   endtask

   // random traffic: mostly full measurements, some broken ones and noise
   task automatic run_random(input int count);
      int            sent, kind, mids;
      touch_req_type r;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // a measurement: seed, averaged pairs, last pair
            // (kind 6 leaves out the seed flag)
            mids = $urandom_range(0, 5);
            for (int k = 0; k <= mids; k++) begin
               r.pen_down   = 1'b1;
               r.raw_x      = rand_coord();
               r.raw_y      = rand_coord();
               r.first_pair = (k == 0) && (kind != 6);
               r.last_pair  = (k == mids);
               send_touch(r, 1'b0, '0);
               sent++;
            end
         end else begin
            // pen-down pair with random flags, or anything at all
            r.pen_down   = (kind == 7) ? 1'b1 : 1'(($urandom_range(0, 1)));
            r.raw_x      = COORD_W'($urandom_range(0, 4095));
            r.raw_y      = COORD_W'($urandom_range(0, 4095));
            r.first_pair = 1'($urandom_range(0, 1));
            r.last_pair  = 1'($urandom_range(0, 1));
            send_touch(r, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // directed row builder
   function automatic touch_row_type make_row(
      input logic pen, input int rx, input int ry, input logic first,
      input logic last, input logic typed, input logic p, input int px, input int py
   );
      touch_row_type row;
      row.req  = {pen, COORD_W'(rx), COORD_W'(ry), first, last};
      row.typed = typed;
      row.want = {p, COORD_W'(px), COORD_W'(py)};
      return row;
   endfunction

   // receiver: random stall bursts, a quiet mode, and one long hold-off
   initial begin
      int n;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            repeat (rand_gap()) @(posedge clock);
         end
      end
   end

   // result checker: every taken point against the oldest expected point
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_pt = {rsp_pressed, rsp_pos_x, rsp_pos_y};
         if (pending_pts.size() == 0) begin
            flag_error($sformatf("unexpected point pressed=%0b x=%0d y=%0d",
                                 seen_pt.pressed, seen_pt.pos_x, seen_pt.pos_y));
         end else begin
            due_pt = pending_pts.pop_front();
            if (seen_pt.pressed !== due_pt.pressed || seen_pt.pos_x !== due_pt.pos_x ||
                seen_pt.pos_y !== due_pt.pos_y)
               flag_error($sformatf("point pressed=%0b x=%0d y=%0d, expected %0b %0d %0d",
                                    seen_pt.pressed, seen_pt.pos_x, seen_pt.pos_y,
                                    due_pt.pressed, due_pt.pos_x, due_pt.pos_y));
         end
      end
   end

   // main sequence
   initial begin
      // shadow state matches the block after reset
      cal_reg[REG_X_OFFSET]      = RST_X_OFFSET;
      cal_reg[REG_Y_OFFSET]      = RST_Y_OFFSET;
      cal_reg[REG_X_TOP]         = RST_X_TOP;
      cal_reg[REG_Y_TOP]         = RST_Y_TOP;
      cal_reg[REG_SCREEN_WIDTH]  = RST_SCREEN_WIDTH;
      cal_reg[REG_SCREEN_HEIGHT] = RST_SCREEN_HEIGHT;
      cal_reg[REG_OPTIONS]       = {{(COORD_W-OPT_W){1'b0}}, RST_OPTIONS};
      accum_x  = '0;
      accum_y  = '0;
      held_x   = '0;
      held_y   = '0;
      win_fill = 0;

      // directed requests at reset calibration, no options
      //                    pen  raw_x raw_y first last  typed pressed x    y
      plan.push_back(make_row(0, 0,    0,    0,    0,    1,    0,      0,   0));   // released right after reset
      plan.push_back(make_row(1, 0,    0,    1,    1,    1,    1,      0,   0));   // seed and emit, below offsets
      plan.push_back(make_row(1, 4095, 4095, 1,    1,    1,    1,      346, 259)); // seed and emit, full scale
      plan.push_back(make_row(0, 4095, 4095, 1,    1,    1,    0,      346, 259)); // released, flags ignored
      plan.push_back(make_row(1, 300,  200,  1,    1,    1,    1,      0,   0));   // exactly at the offsets
      plan.push_back(make_row(1, 1000, 2000, 1,    0,    0,    0,      0,   0));   // seed only
      plan.push_back(make_row(1, 3000, 500,  0,    0,    0,    0,      0,   0));   // averaged in
      plan.push_back(make_row(1, 0,    1234, 0,    0,    0,    0,      0,   0));   // zero x, skipped
      plan.push_back(make_row(1, 777,  0,    0,    0,    0,    0,      0,   0));   // zero y, skipped
      plan.push_back(make_row(1, 2222, 3333, 0,    1,    0,    0,      0,   0));   // last pair
      plan.push_back(make_row(0, 0,    0,    0,    0,    0,    0,      0,   0));   // released after a point
      plan.push_back(make_row(1, 4095, 1,    0,    1,    0,    0,      0,   0));   // last pair with no seed
      plan.push_back(make_row(1, 5,    5,    1,    0,    0,    0,      0,   0));   // small seed
      plan.push_back(make_row(1, 4095, 4095, 0,    0,    0,    0,      0,   0));   // top values averaged
      plan.push_back(make_row(1, 0,    0,    0,    1,    0,    0,      0,   0));   // last pair with zeros
      plan.push_back(make_row(0, 4095, 0,    1,    0,    0,    0,      0,   0));   // released, seed flag set

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) send_touch(plan[i].req, plan[i].typed, plan[i].want);

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         // sender pauses until every owed point is back before reprogramming
         wait_idle();
         program_phase(phase);
         quiet = (phase == 3);
         // block fills up behind a long receiver hold-off
         if (phase == 4) long_hold_req = 1'b1;
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      if (pending_pts.size() != 0)
         flag_error($sformatf("%0d points never arrived", pending_pts.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
